// ===== rtl/oblt_pkg.sv =====
// Shared types, codes and saturating helpers for the order book level table.
// Used by order_book_level_table_core; depends on nothing else.
package oblt_pkg;

    // Request kinds carried on s_req_type.
    typedef enum logic [1:0] {
        RT_ADD = 2'd0,
        RT_UPD = 2'd1,
        RT_DEL = 2'd2,
        RT_BAD = 2'd3
    } req_type_t;

    // Result status codes carried on m_status.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_DUP     = 2'd3
    } status_t;

    localparam int unsigned ID_W    = 64;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned PRI_W   = 64;
    localparam int unsigned TOTAL_W = 42;
    localparam int unsigned COUNT_W = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Addition that clamps at the largest level total.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [SIZE_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {{(TOTAL_W+1-SIZE_W){1'b0}}, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    // Subtraction that clamps at zero.
    function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                   input logic [SIZE_W-1:0] b);
        logic [TOTAL_W-1:0] bx;
        bx = {{(TOTAL_W-SIZE_W){1'b0}}, b};
        return (bx > a) ? '0 : a - bx;
    endfunction

endpackage

// ===== rtl/order_book_level_table_core.sv =====
// Order book level table: order slot memory, price level memory and the scan sequencer.
// Depends on oblt_pkg for request and status codes and the saturating helpers.
//
//   Channel | Direction | Ports
//   s_      | in        | s_valid, s_ready, s_req_type, s_order_id, s_side, s_price,
//           |           | s_order_size, s_priority_req
//   m_      | out       | m_valid, m_ready, m_status, m_level_present, m_level_side,
//           |           | m_level_price, m_level_total, m_level_orders
//
// A request is answered after the scans, CALC and WRITE, and the next one can be taken
// once the block is back in IDLE: every slot and then every level is read once through the
// single read port of its memory, one entry a cycle, then CALC computes the result and
// WRITE writes it back. An invalid request type skips the scans and goes to WRITE.
// After reset a clearing pass over every slot and level runs while s_ready is low.
// A result waits in the output register while the next request is taken; the block
// stalls only at write-back when that register is still full.
module order_book_level_table_core
    import oblt_pkg::*;
#(
    parameter int unsigned MAX_ORDERS = 1024,
    parameter int unsigned MAX_LEVELS = 256,
    parameter int unsigned PRICE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_order_id,
    input  logic        s_side,
    input  logic [31:0] s_price,
    input  logic [31:0] s_order_size,
    input  logic [63:0] s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_level_present,
    output logic        m_level_side,
    output logic [31:0] m_level_price,
    output logic [41:0] m_level_total,
    output logic [10:0] m_level_orders
);

    localparam int unsigned KW    = (PRICE_BITS < 32) ? PRICE_BITS : 32;
    localparam int unsigned OW    = $clog2(MAX_ORDERS);
    localparam int unsigned LW    = $clog2(MAX_LEVELS);
    localparam int unsigned CLR_N = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
    localparam int unsigned CW    = $clog2(CLR_N + 1);

    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic              side;
        logic [KW-1:0]     price;
        logic [SIZE_W-1:0] size;
        logic [PRI_W-1:0]  pri;
    } slot_word_t;

    typedef struct packed {
        logic               vld;
        logic               side;
        logic [KW-1:0]      price;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } lvl_word_t;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_OSCAN = 6'b000100,
        S_LSCAN = 6'b001000,
        S_CALC  = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Memories with registered read data.
    slot_word_t slot_mem [MAX_ORDERS];
    lvl_word_t  lvl_mem  [MAX_LEVELS];
    slot_word_t slot_rdata_reg;
    lvl_word_t  lvl_rdata_reg;
    logic       slot_we, lvl_we;
    logic [OW-1:0] slot_waddr;
    logic [LW-1:0] lvl_waddr;
    slot_word_t slot_wdata;
    lvl_word_t  lvl_wdata;

    // Counters for the clearing pass and the scans.
    logic [CW-1:0] cnt_reg;
    logic          rd_vld_reg;
    logic [CW-1:0] rd_idx_reg;

    // Request held for the whole operation.
    logic [1:0]        rq_type_reg;
    logic [ID_W-1:0]   rq_id_reg;
    logic              rq_side_reg;
    logic [KW-1:0]     rq_price_reg;
    logic [SIZE_W-1:0] rq_size_reg;
    logic [PRI_W-1:0]  rq_pri_reg;

    // Scan findings.
    logic          o_found_reg, s_found_reg, l_found_reg, f_found_reg;
    logic [OW-1:0] o_idx_reg, s_idx_reg;
    logic [LW-1:0] l_idx_reg, f_idx_reg;
    slot_word_t    o_word_reg;
    lvl_word_t     l_word_reg;

    // Values worked out before write-back.
    logic [1:0]         status_reg;
    logic [TOTAL_W-1:0] t1_reg;
    logic [SIZE_W-1:0]  addend_reg;
    logic [COUNT_W-1:0] cnt_new_reg;

    // Output register.
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic               m_present_reg;
    logic               m_side_reg;
    logic [31:0]        m_price_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic [COUNT_W-1:0] m_orders_reg;

    logic               out_free;
    logic [KW-1:0]      lkey;
    logic               o_scan_done, l_scan_done, clr_done;
    logic               issue;
    logic [TOTAL_W-1:0] tot_new;
    logic [TOTAL_W-1:0] base_tot;
    logic [COUNT_W-1:0] base_cnt;
    logic               res_present;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_level_present = m_present_reg;
    assign m_level_side    = m_side_reg;
    assign m_level_price   = m_price_reg;
    assign m_level_total   = m_total_reg;
    assign m_level_orders  = m_orders_reg;

    assign out_free = !m_valid_reg || m_ready;

    // The level key: the request price, or for a delete the stored price (zero if unknown).
    assign lkey = (rq_type_reg == RT_DEL) ? (o_found_reg ? o_word_reg.price : '0)
                                          : rq_price_reg;

    assign o_scan_done = rd_vld_reg && (rd_idx_reg == CW'(MAX_ORDERS - 1));
    assign l_scan_done = rd_vld_reg && (rd_idx_reg == CW'(MAX_LEVELS - 1));
    assign clr_done    = (cnt_reg == CW'(CLR_N - 1));
    assign issue       = ((state_reg == S_OSCAN) && (cnt_reg < CW'(MAX_ORDERS))) ||
                         ((state_reg == S_LSCAN) && (cnt_reg < CW'(MAX_LEVELS)));

    assign tot_new  = sat_add(t1_reg, addend_reg);
    assign base_tot = l_found_reg ? l_word_reg.total : '0;
    assign base_cnt = l_found_reg ? l_word_reg.count : '0;

    // Level presence after the step, as reported in the result.
    always_comb begin
        if (status_reg != ST_OK) begin
            res_present = l_found_reg;
        end else begin
            case (rq_type_reg)
                RT_ADD:  res_present = 1'b1;
                RT_DEL:  res_present = l_found_reg && (cnt_new_reg != '0);
                default: res_present = l_found_reg;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_done) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_req_type == RT_BAD) ? S_WRITE : S_OSCAN;
                end
            end
            S_OSCAN: if (o_scan_done) state_next = S_LSCAN;
            S_LSCAN: if (l_scan_done) state_next = S_CALC;
            S_CALC:  state_next = S_WRITE;
            S_WRITE: if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Memory write ports: the clearing pass, then write-back of the step.
    always_comb begin
        slot_we    = 1'b0;
        lvl_we     = 1'b0;
        slot_waddr = cnt_reg[OW-1:0];
        lvl_waddr  = cnt_reg[LW-1:0];
        slot_wdata = '0;
        lvl_wdata  = '0;
        if (state_reg == S_CLEAR) begin
            slot_we = (cnt_reg < CW'(MAX_ORDERS));
            lvl_we  = (cnt_reg < CW'(MAX_LEVELS));
        end else if ((state_reg == S_WRITE) && out_free && (rq_type_reg != RT_BAD) &&
                     (status_reg == ST_OK)) begin
            case (rq_type_reg)
                RT_ADD: begin
                    slot_we    = 1'b1;
                    slot_waddr = s_idx_reg;
                    slot_wdata = '{vld: 1'b1, id: rq_id_reg, side: rq_side_reg,
                                   price: rq_price_reg, size: rq_size_reg, pri: rq_pri_reg};
                    lvl_we     = 1'b1;
                    lvl_waddr  = l_found_reg ? l_idx_reg : f_idx_reg;
                    lvl_wdata  = '{vld: 1'b1, side: rq_side_reg, price: lkey,
                                   total: tot_new, count: cnt_new_reg};
                end
                RT_UPD: begin
                    slot_we    = 1'b1;
                    slot_waddr = o_idx_reg;
                    slot_wdata = o_word_reg;
                    slot_wdata.size = rq_size_reg;
                    slot_wdata.pri  = rq_pri_reg;
                    lvl_we     = l_found_reg;
                    lvl_waddr  = l_idx_reg;
                    lvl_wdata  = '{vld: 1'b1, side: rq_side_reg, price: lkey,
                                   total: tot_new, count: cnt_new_reg};
                end
                default: begin
                    slot_we    = 1'b1;
                    slot_waddr = o_idx_reg;
                    lvl_we     = l_found_reg;
                    lvl_waddr  = l_idx_reg;
                    lvl_wdata  = '{vld: (cnt_new_reg != '0), side: rq_side_reg, price: lkey,
                                   total: tot_new, count: cnt_new_reg};
                end
            endcase
        end
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[cnt_reg[OW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        lvl_rdata_reg <= lvl_mem[cnt_reg[LW-1:0]];
    end

    // Control state: FSM, counters, scan flags and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            o_found_reg <= 1'b0;
            s_found_reg <= 1'b0;
            l_found_reg <= 1'b0;
            f_found_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            if (issue || ((state_reg == S_CLEAR) && !clr_done)) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (clr_done || o_scan_done || l_scan_done) begin
                cnt_reg <= '0;
            end

            if (s_valid && s_ready) begin
                o_found_reg <= 1'b0;
                s_found_reg <= 1'b0;
                l_found_reg <= 1'b0;
                f_found_reg <= 1'b0;
            end

            // Slot scan: first live entry with the id, first free entry.
            if ((state_reg == S_OSCAN) && rd_vld_reg) begin
                if (slot_rdata_reg.vld && (slot_rdata_reg.id == rq_id_reg) && !o_found_reg) begin
                    o_found_reg <= 1'b1;
                end
                if (!slot_rdata_reg.vld && !s_found_reg) begin
                    s_found_reg <= 1'b1;
                end
            end

            // Level scan: first live level with the key, first free level.
            if ((state_reg == S_LSCAN) && rd_vld_reg) begin
                if (lvl_rdata_reg.vld && (lvl_rdata_reg.side == rq_side_reg) &&
                    (lvl_rdata_reg.price == lkey) && !l_found_reg) begin
                    l_found_reg <= 1'b1;
                end
                if (!lvl_rdata_reg.vld && !f_found_reg) begin
                    f_found_reg <= 1'b1;
                end
            end

            // A new result replaces the one just taken; otherwise a taken result empties it.
            if ((state_reg == S_WRITE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;

        if (s_valid && s_ready) begin
            rq_type_reg  <= s_req_type;
            rq_id_reg    <= s_order_id;
            rq_side_reg  <= s_side;
            rq_price_reg <= KW'(s_price);
            rq_size_reg  <= s_order_size;
            rq_pri_reg   <= s_priority_req;
        end

        if ((state_reg == S_OSCAN) && rd_vld_reg) begin
            if (slot_rdata_reg.vld && (slot_rdata_reg.id == rq_id_reg) && !o_found_reg) begin
                o_idx_reg  <= rd_idx_reg[OW-1:0];
                o_word_reg <= slot_rdata_reg;
            end
            if (!slot_rdata_reg.vld && !s_found_reg) begin
                s_idx_reg <= rd_idx_reg[OW-1:0];
            end
        end

        if ((state_reg == S_LSCAN) && rd_vld_reg) begin
            if (lvl_rdata_reg.vld && (lvl_rdata_reg.side == rq_side_reg) &&
                (lvl_rdata_reg.price == lkey) && !l_found_reg) begin
                l_idx_reg  <= rd_idx_reg[LW-1:0];
                l_word_reg <= lvl_rdata_reg;
            end
            if (!lvl_rdata_reg.vld && !f_found_reg) begin
                f_idx_reg <= rd_idx_reg[LW-1:0];
            end
        end

        // Status and the first half of the level arithmetic.
        if (state_reg == S_CALC) begin
            case (rq_type_reg)
                RT_ADD: begin
                    if (o_found_reg) begin
                        status_reg <= ST_DUP;
                    end else if (!s_found_reg || (!l_found_reg && !f_found_reg)) begin
                        status_reg <= ST_FULL;
                    end else begin
                        status_reg <= ST_OK;
                    end
                    t1_reg      <= base_tot;
                    addend_reg  <= rq_size_reg;
                    cnt_new_reg <= (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + COUNT_W'(1);
                end
                RT_UPD: begin
                    status_reg  <= o_found_reg ? ST_OK : ST_UNKNOWN;
                    t1_reg      <= sat_sub(base_tot, o_word_reg.size);
                    addend_reg  <= rq_size_reg;
                    cnt_new_reg <= base_cnt;
                end
                default: begin
                    status_reg  <= o_found_reg ? ST_OK : ST_UNKNOWN;
                    t1_reg      <= sat_sub(base_tot, o_word_reg.size);
                    addend_reg  <= '0;
                    cnt_new_reg <= ((o_word_reg.side == rq_side_reg) && (base_cnt != '0)) ?
                                   base_cnt - COUNT_W'(1) : base_cnt;
                end
            endcase
        end

        // Result of the step.
        if ((state_reg == S_WRITE) && out_free) begin
            if (rq_type_reg == RT_BAD) begin
                m_status_reg  <= ST_UNKNOWN;
                m_present_reg <= 1'b0;
                m_side_reg    <= 1'b0;
                m_price_reg   <= '0;
                m_total_reg   <= '0;
                m_orders_reg  <= '0;
            end else begin
                m_status_reg  <= status_reg;
                m_present_reg <= res_present;
                m_side_reg    <= rq_side_reg;
                m_price_reg   <= 32'(lkey);
                if (!res_present) begin
                    m_total_reg  <= '0;
                    m_orders_reg <= '0;
                end else if (status_reg == ST_OK) begin
                    m_total_reg  <= tot_new;
                    m_orders_reg <= cnt_new_reg;
                end else begin
                    m_total_reg  <= l_word_reg.total;
                    m_orders_reg <= l_word_reg.count;
                end
            end
        end
    end

endmodule
